@@ hdl/scfp_pkg.sv @@
// types shared by the serial command frame parser and its channel interfaces
package scfp_pkg;

  localparam logic [7:0] HdrMark   = 8'h80;
  localparam logic [7:0] HdrTarget = 8'h40;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       line_error;
  } rx_word_t;

  typedef struct packed {
    logic        frame_target;
    logic [15:0] first_word;
    logic [15:0] second_word;
  } frame_word_t;

endpackage

@@ hdl/scfp_if.sv @@
// valid/ready channel interfaces for received bytes and decoded frames
interface scfp_rx_if import scfp_pkg::*;;
  logic     valid;
  logic     ready;
  rx_word_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface scfp_frame_if import scfp_pkg::*;;
  logic        valid;
  logic        ready;
  frame_word_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

@@ hdl/serial_command_frame_parser.sv @@
// serial command frame parser: header and data bytes in, decoded frame words out
//
//   channel   dir  word                                    accepted when
//   rx_i      in   rx_byte, line_error                     valid & ready
//   frame_o   out  frame_target, first_word, second_word   valid & ready
//
// one byte per cycle unless rx_i stalls; a frame leaves, after its fourth data byte,
// from a single output register backed by a one-word skid register
// rx_i stalls only while the skid register holds a frame
// reset clears the phase, header bits, target, both words and the valid flags
module serial_command_frame_parser import scfp_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  scfp_rx_if.sink           rx_i,
  scfp_frame_if.source      frame_o
);

  typedef enum logic [2:0] {
    PhIdle,
    PhHiOne,
    PhLoOne,
    PhHiTwo,
    PhLoTwo
  } phase_e;

  phase_e      phase_q, phase_d;
  logic [3:0]  hdr_bits_q, hdr_bits_d;
  logic        target_q, target_d;
  logic [15:0] word_one_q, word_one_d;
  logic [15:0] word_two_q, word_two_d;

  frame_word_t out_q, skid_q, res;
  logic        out_vld_q, skid_vld_q;
  logic        in_fire, out_fire, res_vld;
  logic [7:0]  b;

  assign rx_i.ready    = !skid_vld_q;
  assign in_fire       = rx_i.valid && rx_i.ready;
  assign out_fire      = out_vld_q && frame_o.ready;
  assign frame_o.valid = out_vld_q;
  assign frame_o.payload = out_q;
  assign b             = rx_i.payload.rx_byte;

  always_comb begin
    phase_d    = phase_q;
    hdr_bits_d = hdr_bits_q;
    target_d   = target_q;
    word_one_d = word_one_q;
    word_two_d = word_two_q;
    res_vld    = 1'b0;
    if (in_fire) begin
      priority if (rx_i.payload.line_error) begin
        phase_d = PhIdle;
      end else if ((b & HdrMark) != 8'h00) begin
        hdr_bits_d = b[3:0];
        target_d   = (b & HdrTarget) != 8'h00;
        phase_d    = PhHiOne;
      end else begin
        unique case (phase_q)
          PhIdle: begin
            phase_d = PhIdle;
          end
          PhHiOne: begin
            word_one_d[15:8] = {hdr_bits_q[0], b[6:0]};
            phase_d = PhLoOne;
          end
          PhLoOne: begin
            word_one_d[7:0] = {hdr_bits_q[1], b[6:0]};
            phase_d = PhHiTwo;
          end
          PhHiTwo: begin
            word_two_d[15:8] = {hdr_bits_q[2], b[6:0]};
            phase_d = PhLoTwo;
          end
          PhLoTwo: begin
            word_two_d[7:0] = {hdr_bits_q[3], b[6:0]};
            phase_d = PhIdle;
            res_vld = 1'b1;
          end
          default: begin
            phase_d = PhIdle;
          end
        endcase
      end
    end
    res.frame_target = target_q;
    res.first_word   = word_one_d;
    res.second_word  = word_two_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PhIdle;
      hdr_bits_q <= 4'h0;
      target_q   <= 1'b0;
      word_one_q <= 16'h0000;
      word_two_q <= 16'h0000;
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else begin
      phase_q    <= phase_d;
      hdr_bits_q <= hdr_bits_d;
      target_q   <= target_d;
      word_one_q <= word_one_d;
      word_two_q <= word_two_d;
      if (skid_vld_q) begin
        if (out_fire) begin
          skid_vld_q <= 1'b0;
        end
      end else if (res_vld) begin
        if (!out_vld_q || out_fire) begin
          out_vld_q <= 1'b1;
        end else begin
          skid_vld_q <= 1'b1;
        end
      end else if (out_fire) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // payload side of the output and skid registers
  always_ff @(posedge clk_i) begin
    if (skid_vld_q) begin
      if (out_fire) begin
        out_q <= skid_q;
      end
    end else if (res_vld) begin
      if (!out_vld_q || out_fire) begin
        out_q <= res;
      end else begin
        skid_q <= res;
      end
    end
  end

endmodule
